### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the comb reverb.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

### rtl/mtcr_pkg.sv
// Package of the comb reverb: register indexes, modes, divider widths and control, sequencer states.
// Depends on nothing.
package mtcr_pkg;
  localparam int unsigned CfgW = 3;
  localparam logic [CfgW-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CfgW-1:0] REG_DECAY  = 3'd1;
  localparam logic [CfgW-1:0] REG_MODE   = 3'd2;
  localparam logic [CfgW-1:0] REG_LEN_A  = 3'd3;
  localparam logic [CfgW-1:0] REG_LEN_B  = 3'd4;
  localparam logic [CfgW-1:0] REG_LEN_C  = 3'd5;
  localparam logic [CfgW-1:0] REG_LEN_D  = 3'd6;
  localparam logic [1:0] MODE_U8  = 2'd0;
  localparam logic [1:0] MODE_S16 = 2'd1;
  localparam int unsigned NumW = 64;
  localparam int unsigned DenW = 20;
  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_WRITE, ST_OUT
  } state_t;
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

### rtl/mtcr_div.sv
// Radix-2 restoring signed divider, truncating toward zero.
// Depends on mtcr_pkg.
module mtcr_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [mtcr_pkg::NumW-1:0] num,
  input  logic [mtcr_pkg::DenW-1:0] den,
  output mtcr_pkg::div_ctl_t ctl,
  output logic signed [mtcr_pkg::NumW-1:0] quo
);
  import mtcr_pkg::*;
  logic [NumW-1:0] q;
  logic [DenW:0] r;
  logic [DenW-1:0] dv;
  logic neg;
  logic [6:0] cnt;
  logic busy;
  logic done;
  logic [DenW:0] trial;
  logic [DenW:0] rs;

  always_comb begin
    rs = {r[DenW-1:0], q[NumW-1]};
    trial = rs - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'(NumW);
        q <= num[NumW-1] ? NumW'(-num) : NumW'(num);
        neg <= num[NumW-1];
        r <= '0;
        dv <= den;
      end else if (busy) begin
        if (trial[DenW]) begin
          r <= rs;
          q <= {q[NumW-2:0], 1'b0};
        end else begin
          r <= trial;
          q <= {q[NumW-2:0], 1'b1};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);
  assign ctl = '{start: start, busy: busy, done: done};
endmodule

### rtl/multi_tap_comb_reverb_top.sv
// Top level of the multi-tap comb reverb: sequencer, delay memory, divider.
// Depends on mtcr_pkg, mtcr_div and assert_macros.svh.
//
// Use: raw samples enter as requests on in_valid/in_ready with in_sample and
// buffer_end; each request gives one result on out_valid/out_ready with
// out_sample and buffer_end_out. Registers are written on cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is high only while no sample is in
// work, and a pending register write holds off the next sample for that cycle.
// Per sample the sequencer reads one delay entry per active line from the single
// delay memory, multiplies the sum by the decay, runs a 64-step serial divider and
// writes y back one line a cycle. One sample is in work at a time; the next is
// accepted only after the result is loaded into the output register and the
// sequencer is back in its idle state. After reset the block clears the delay
// memory one entry a cycle and accepts no sample until it is done.
// When the receiver stalls the result stays in the output register while the
// next sample is processed; that sample then waits in its last step, and no
// further sample is accepted until the output register is free.
module multi_tap_comb_reverb_top #(
  parameter int unsigned NUM_LINES = 4,
  parameter int unsigned MAX_LINE_LEN = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [31:0] in_sample,
  input  logic buffer_end,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] out_sample,
  output logic buffer_end_out,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mtcr_pkg::CfgW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import mtcr_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PW = $clog2(MAX_LINE_LEN);
  localparam int unsigned LW = $clog2(NUM_LINES) > 0 ? $clog2(NUM_LINES) : 1;
  localparam int unsigned AW = PW + LW;
  localparam int unsigned DEPTH = NUM_LINES * MAX_LINE_LEN;
  localparam int unsigned NW = $clog2(NUM_LINES + 1);

  // Configuration registers.
  logic [2:0] active_lines;
  logic [15:0] decay_gain;
  logic [1:0] sample_mode;
  logic [12:0] line_len [4];

  // Memory and position state.
  logic signed [39:0] mem [DEPTH];
  logic signed [39:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic signed [39:0] wr_data;
  logic [PW-1:0] pos [NUM_LINES];

  state_t state, state_next;
  logic [AW:0] clr_cnt;
  logic [LW:0] line_idx;
  logic rd_pend;
  logic [NW-1:0] n_lines;
  logic signed [33:0] x;
  logic signed [48:0] acc;
  logic signed [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic signed [39:0] y;
  logic be;
  logic [31:0] out_reg;
  logic out_free;
  logic div_start;
  div_ctl_t div_ctl;
  logic signed [NumW-1:0] quo;

  // Registers change only between samples, so a sample sees one setting throughout.
  assign cfg_ready = (state == ST_IDLE) || (state == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_lines <= 3'd4;
      decay_gain <= 16'd2048;
      sample_mode <= MODE_S16;
      line_len[0] <= 13'd1024;
      line_len[1] <= 13'd2048;
      line_len[2] <= 13'd3072;
      line_len[3] <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE: active_lines <= cfg_data[2:0];
        REG_DECAY:  decay_gain <= cfg_data[15:0];
        REG_MODE:   sample_mode <= cfg_data[1:0];
        REG_LEN_A:  line_len[0] <= cfg_data[12:0];
        REG_LEN_B:  line_len[1] <= cfg_data[12:0];
        REG_LEN_C:  line_len[2] <= cfg_data[12:0];
        REG_LEN_D:  line_len[3] <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Effective length of a line, limited to 1..MAX_LINE_LEN.
  function automatic logic [PW:0] eff_len(input int unsigned i,
                                          input logic [12:0] l0, input logic [12:0] l1,
                                          input logic [12:0] l2, input logic [12:0] l3);
    logic [16:0] l;
    l = 17'(MAX_LINE_LEN);
    unique case (i)
      0: l = 17'(l0);
      1: l = 17'(l1);
      2: l = 17'(l2);
      3: l = 17'(l3);
      default: ;
    endcase
    if (l == 17'd0) l = 17'd1;
    if (l > 17'(MAX_LINE_LEN)) l = 17'(MAX_LINE_LEN);
    return (PW+1)'(l);
  endfunction

  logic [LW-1:0] li;
  assign li = line_idx[LW-1:0];

  always_comb begin
    rd_addr = {li, pos[li]};
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = rd_addr;
    wr_data = y;
    if (state == ST_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_cnt[AW-1:0];
      wr_data = '0;
    end else if (state == ST_WRITE) begin
      wr_en = 1'b1;
    end
  end

  // The output register is free when it is empty or being emptied this cycle.
  assign out_free = !out_valid || out_ready;

  assign in_ready = (state == ST_IDLE) && !cfg_valid;
  assign div_start = (state == ST_MUL);

  // Divider operands, taken by the divider at the edge that ends ST_MUL.
  always_comb begin
    num = 64'(x) * 64'sd1048576 + $signed({1'b0, decay_gain}) * 64'(acc);
    den = DenW'(4096 + 20'(n_lines) * 20'(decay_gain));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid && in_ready) state_next = ST_READ;
      ST_READ:  if (line_idx == (LW+1)'(n_lines) && !rd_pend) state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   if (div_ctl.done) state_next = (n_lines == '0) ? ST_OUT : ST_WRITE;
      ST_WRITE: if (line_idx == (LW+1)'(n_lines - NW'(1))) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  logic signed [63:0] v;
  always_comb begin
    v = (64'(y) + ((sample_mode == MODE_U8) ? 64'sd32768 : 64'sd0)) / 64'sd256;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      line_idx <= '0;
      rd_pend <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) pos[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: if (in_valid && in_ready) begin
          be <= buffer_end;
          n_lines <= (active_lines > 3'(NUM_LINES)) ? NW'(NUM_LINES) : NW'(active_lines);
          unique case (sample_mode)
            MODE_U8:  x <= $signed({26'd0, in_sample[7:0]}) - 34'sd128;
            MODE_S16: x <= 34'($signed(in_sample[15:0]));
            default:  x <= 34'($signed(in_sample));
          endcase
          acc <= '0;
          line_idx <= '0;
          rd_pend <= 1'b0;
        end
        ST_READ: begin
          if (rd_pend) acc <= acc + 49'(rd_data);
          rd_pend <= (line_idx != (LW+1)'(n_lines));
          if (line_idx != (LW+1)'(n_lines)) line_idx <= line_idx + 1'b1;
        end
        ST_MUL: begin
          line_idx <= '0;
        end
        ST_DIV: if (div_ctl.done) begin
          if (quo > 64'sd549755813887) y <= 40'sh7FFFFFFFFF;
          else if (quo < -64'sd549755813888) y <= 40'sh8000000000;
          else y <= 40'(quo);
        end
        ST_WRITE: begin
          line_idx <= line_idx + 1'b1;
          if ((PW+1)'(pos[li]) + 1'b1 >= eff_len(32'(li), line_len[0], line_len[1],
                                                 line_len[2], line_len[3]))
            pos[li] <= '0;
          else
            pos[li] <= pos[li] + 1'b1;
        end
        ST_OUT: if (out_free) begin
          buffer_end_out <= be;
          unique case (sample_mode)
            MODE_U8:  out_reg <= (v > 255) ? 32'd255 : (v < 0) ? 32'd0 : {24'd0, v[7:0]};
            MODE_S16: out_reg <= (v > 32767) ? 32'h7FFF : (v < -32768) ? 32'h8000 :
                                 {16'd0, v[15:0]};
            default:  out_reg <= (v > 64'sd2147483647) ? 32'h7FFFFFFF :
                                 (v < -64'sd2147483648) ? 32'h80000000 : v[31:0];
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_sample = out_reg;

  mtcr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .ctl(div_ctl), .quo(quo)
  );

  `ASSERT_IMPLY(a_no_accept_clear, clk, rst, state == ST_CLEAR, !in_ready)
  `ASSERT_IMPLY(a_div_done_state, clk, rst, div_ctl.done, state == ST_DIV)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_sample))
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for multi_tap_comb_reverb_top: directed and random samples.
// Depends on mtcr_pkg and the comb reverb RTL; predicts every result in-line.
module tb_top;
  import mtcr_pkg::*;

  // Sizes match the block's default parameters.
  localparam int NumLines = 4;
  localparam int MaxLen = 4096;
  localparam logic [1:0] MODE_S32 = 2'd2;
  localparam logic [1:0] MODE_ODD = 2'd3;
  localparam logic [CfgW-1:0] REG_NONE = 3'd7;
  localparam int IdleLimit = 60000;
  localparam int DrainCycles = 200;
  localparam longint Q8Max = 64'sd549755813887;
  localparam longint Q8Min = -64'sd549755813888;

  typedef struct {
    logic [31:0] sample;
    logic        last;
  } echo_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_sample = '0;
  logic buffer_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_sample;
  logic buffer_end_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the block's registers and delay memory.
  logic [2:0] active_r;
  logic [15:0] decay_r;
  logic [1:0] mode_r;
  logic [12:0] len_r [4];
  longint delay_mem [NumLines * MaxLen];
  int line_pos [NumLines];

  echo_result_t echo_q [$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int long_hold = 0;
  int ready_pct = 100;

  always #2 clk = ~clk;

  multi_tap_comb_reverb_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .buffer_end(buffer_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sample(out_sample), .buffer_end_out(buffer_end_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int eff_len(int i);
    int l;
    l = len_r[i];
    if (l == 0) l = 1;
    if (l > MaxLen) l = MaxLen;
    return l;
  endfunction

  function automatic int mem_slot(int i);
    int p;
    p = line_pos[i];
    if (p >= MaxLen) p = MaxLen - 1;
    return i * MaxLen + p;
  endfunction

  // Computes the echo output for one raw sample and updates the delay lines.
  function automatic logic [31:0] predict_echo(logic [31:0] raw);
    longint x, off, lo, hi, sum, num, den, y, v;
    logic [31:0] mask;
    int n;
    case (mode_r)
      MODE_U8: begin
        x = longint'(raw[7:0]) - 128; off = 128; lo = 0; hi = 255;
        mask = 32'h0000_00FF;
      end
      MODE_S16: begin
        x = longint'($signed(raw[15:0])); off = 0; lo = -32768; hi = 32767;
        mask = 32'h0000_FFFF;
      end
      default: begin
        x = longint'($signed(raw)); off = 0; lo = -64'sd2147483648;
        hi = 64'sd2147483647; mask = 32'hFFFF_FFFF;
      end
    endcase
    n = (active_r > NumLines) ? NumLines : int'(active_r);
    sum = 0;
    for (int i = 0; i < n; i++) sum += delay_mem[mem_slot(i)];
    num = x * 1048576 + longint'(decay_r) * sum;
    den = 4096 + longint'(n) * longint'(decay_r);
    y = num / den;
    if (y > Q8Max) y = Q8Max;
    if (y < Q8Min) y = Q8Min;
    for (int i = 0; i < n; i++) begin
      delay_mem[mem_slot(i)] = y;
      line_pos[i] = (line_pos[i] + 1 >= eff_len(i)) ? 0 : line_pos[i] + 1;
    end
    v = (y + off * 256) / 256;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return 32'(v) & mask;
  endfunction

  // Receiver: a rotating ready rate, plus a long hold-off on request.
  always @(posedge clk) begin
    if (long_hold > 0) begin
      out_ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 80;
        2: ready_pct <= 40;
        default: ready_pct <= 10;
      endcase
    end
  end

  // Result checker: each result must match the oldest prediction.
  always @(posedge clk) begin
    echo_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (echo_q.size() == 0) begin
        $error("result with no request pending: out_sample %h", out_sample);
        errors++;
      end else begin
        want = echo_q.pop_front();
        if (out_sample !== want.sample) begin
          $error("out_sample expected %h actual %h", want.sample, out_sample);
          errors++;
        end
        if (buffer_end_out !== want.last) begin
          $error("buffer_end_out expected %b actual %b", want.last, buffer_end_out);
          errors++;
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one request; valid stays high across a burst and drops only for a gap.
  task automatic send_sample(logic [31:0] raw, logic last);
    echo_result_t item;
    in_valid <= 1'b1;
    in_sample <= raw;
    buffer_end <= last;
    do @(posedge clk); while (!in_ready);
    item.sample = predict_echo(raw);
    item.last = last;
    echo_q.push_back(item);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Ends any burst and waits until every result is back and the block is idle.
  task automatic wait_idle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (echo_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    burst_left = 1;
  endtask

  task automatic write_reg(logic [CfgW-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ACTIVE: active_r = value[2:0];
      REG_DECAY:  decay_r = value[15:0];
      REG_MODE:   mode_r = value[1:0];
      REG_LEN_A:  len_r[0] = value[12:0];
      REG_LEN_B:  len_r[1] = value[12:0];
      REG_LEN_C:  len_r[2] = value[12:0];
      REG_LEN_D:  len_r[3] = value[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_lengths(int a, int b, int c, int d);
    write_reg(REG_LEN_A, a);
    write_reg(REG_LEN_B, b);
    write_reg(REG_LEN_C, c);
    write_reg(REG_LEN_D, d);
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
      3: return {16'($urandom), 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
      default: return $urandom;
    endcase
  endfunction

  function automatic int random_length();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return MaxLen;
      3: return 8191;
      4: return $urandom_range(0, 8191);
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  // Field extremes in each mode, with saturation after a switch to a narrower mode.
  task automatic test_directed();
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'h0000_8000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    wait_idle();
    write_reg(REG_MODE, 32'(MODE_S32));
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    wait_idle();
    // Large stored echoes now drive the 8-bit output into its limits.
    write_reg(REG_MODE, 32'(MODE_U8));
    send_sample(32'hFFFF_FF00, 1'b0);
    send_sample(32'h0000_00FF, 1'b1);
    send_sample(32'h0000_0080, 1'b0);
    wait_idle();
    // Mode three behaves as signed 32-bit; an unknown index changes nothing.
    write_reg(REG_MODE, 32'(MODE_ODD));
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h1234_5678, 1'b0);
    wait_idle();
    // No active lines passes the sample through; too many lines saturates to four.
    write_reg(REG_ACTIVE, 0);
    send_sample(32'hDEAD_BEEF, 1'b0);
    wait_idle();
    write_reg(REG_ACTIVE, 7);
    write_reg(REG_DECAY, 32'h0000_FFFF);
    send_sample(32'h4000_0000, 1'b0);
    send_sample(32'hC000_0000, 1'b1);
    wait_idle();
    // Length zero, the maximum, and a value past the maximum.
    set_lengths(0, 1, MaxLen, 8191);
    write_reg(REG_DECAY, 0);
    send_sample(32'h0000_0100, 1'b0);
    send_sample(32'hFFFF_FF00, 1'b1);
    wait_idle();
  endtask

  // Long lines first, then shrink them so positions sit past the new end.
  task automatic test_shrink();
    write_reg(REG_ACTIVE, 4);
    write_reg(REG_DECAY, 2048);
    write_reg(REG_MODE, 32'(MODE_S16));
    set_lengths(40, 50, 60, 70);
    repeat (30) send_sample(random_sample(), 1'(($urandom_range(0, 1))));
    wait_idle();
    set_lengths(5, 3, 1, 0);
    repeat (20) send_sample(random_sample(), 1'(($urandom_range(0, 1))));
    wait_idle();
  endtask

  // Random settings per phase with random samples in bursts.
  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      wait_idle();
      write_reg(REG_ACTIVE, (ph % 3 == 0) ? 32'($urandom_range(1, 4)) : $urandom);
      case ($urandom_range(0, 3))
        0: write_reg(REG_DECAY, 0);
        1: write_reg(REG_DECAY, 32'hFFFF);
        default: write_reg(REG_DECAY, $urandom);
      endcase
      write_reg(REG_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'(ph)});
      set_lengths(random_length(), random_length(), random_length(), random_length());
      repeat (per_phase) send_sample(random_sample(), 1'(($urandom_range(0, 3) == 0)));
    end
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering; then a full drain pause.
  task automatic test_backpressure();
    write_reg(REG_ACTIVE, 3);
    write_reg(REG_MODE, 32'(MODE_S16));
    set_lengths(7, 11, 13, 17);
    long_hold = 600;
    burst_left = 40;
    repeat (20) send_sample($urandom, 1'(($urandom_range(0, 1))));
    in_valid <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk);
    burst_left = 1;
    repeat (20) send_sample($urandom, 1'(($urandom_range(0, 1))));
    wait_idle();
  endtask

  initial begin
    active_r = 3'd4;
    decay_r = 16'd2048;
    mode_r = MODE_S16;
    len_r[0] = 13'd1024;
    len_r[1] = 13'd2048;
    len_r[2] = 13'd3072;
    len_r[3] = 13'd4096;
    foreach (delay_mem[i]) delay_mem[i] = 0;
    foreach (line_pos[i]) line_pos[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_shrink();
    test_backpressure();
    test_random(10, 130);
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
